@@ rtl/rpa_pkg.sv @@
// Shared constants, codes and control types of the reference-counted page allocator.
package rpa_pkg;

	localparam int MAX_PAGES  = 32768;
	localparam int PAGE_BYTES = 4096;
	localparam int COUNT_BITS = 8;

	localparam int ADDR_W     = 32;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int IDX_W      = $clog2(MAX_PAGES);
	localparam int DEPTH_W    = $clog2(MAX_PAGES + 1);
	localparam int PG_W       = ADDR_W - PAGE_SHIFT;
	localparam int FUNC_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int NCOUNT_W   = 8;
	localparam int CFG_IDX_W  = 1;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_INCREF = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BADADDR  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'd1;

	localparam logic [ADDR_W-1:0] RESET_REGION_START = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] RESET_REGION_END   = 32'h8800_0000;
	localparam logic [ADDR_W:0]   RESET_BASE         = {1'b0, RESET_REGION_START};
	localparam logic [DEPTH_W-1:0] RESET_TOTAL       = DEPTH_W'(MAX_PAGES);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic decode;
		logic execute;
		logic finish;
		logic restart;
	} ctl_cmd_t;

	typedef struct packed {
		logic needs_exec;
	} dp_sts_t;

endpackage

@@ rtl/refcounted_page_allocator.sv @@
// Allocate, bad address and no-op requests finish in the decode state; free and add-reference
// requests on a valid page go on to the execute state, which uses the registered count read.
// done is a registered strobe; a new request can be taken in the cycle that done is shown, but
// none while a request is in the decode or execute state or while the pool restarts.
// Reset (arst_n low) restores the region registers and frees every page of the region at once; every
// configuration write restarts the pool in the following cycle, during which busy is high.
module refcounted_page_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rpa_pkg::FUNC_W-1:0]    func,
	input  logic [rpa_pkg::ADDR_W-1:0]    page_address,
	input  logic                          cfg_we,
	input  logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpa_pkg::ADDR_W-1:0]    cfg_wdata,
	output logic                          done,
	output logic [rpa_pkg::ADDR_W-1:0]    granted_address,
	output logic [rpa_pkg::STATUS_W-1:0]  status,
	output logic                          page_released,
	output logic [rpa_pkg::NCOUNT_W-1:0]  new_count
);

	import rpa_pkg::*;

	// The controller sequences each request through a decode cycle, in which the
	// address is turned into a page index and an allocation is completed, and an
	// optional execute cycle, in which the reference count read from memory is
	// updated for a free or an add-reference request.
	ctl_cmd_t cmd;
	dp_sts_t  sts;

	rpa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cfg_we(cfg_we),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	// The datapath holds the region registers, the pool counters, both memories and
	// the result registers that drive the request outputs until the next request finishes.
	rpa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.func           (func),
		.page_address   (page_address),
		.done           (done),
		.granted_address(granted_address),
		.status         (status),
		.page_released  (page_released),
		.new_count      (new_count)
	);

endmodule

@@ rtl/rpa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/rpa_ctrl.sv @@
// Controller state machine of the page allocator.
module rpa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             cfg_we,
	input  rpa_pkg::dp_sts_t sts,
	output rpa_pkg::ctl_cmd_t cmd,
	output logic             busy
);

	import rpa_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       restart_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			restart_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			restart_q <= cfg_we;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		busy        = restart_q;
		cmd.restart = restart_q;
		case (state_q)
			S_IDLE: begin
				if (start && !restart_q) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				busy       = 1'b1;
				cmd.decode = 1'b1;
				if (sts.needs_exec) begin
					state_d = S_EXEC;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_EXEC: begin
				busy        = 1'b1;
				cmd.execute = 1'b1;
				cmd.finish  = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/rpa_dp.sv @@
// Datapath of the page allocator: region registers, pool state, memories and results.
module rpa_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rpa_pkg::ctl_cmd_t                 cmd,
	output rpa_pkg::dp_sts_t                  sts,
	input  logic                              cfg_we,
	input  logic [rpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rpa_pkg::ADDR_W-1:0]        cfg_wdata,
	input  logic [rpa_pkg::FUNC_W-1:0]        func,
	input  logic [rpa_pkg::ADDR_W-1:0]        page_address,
	output logic                              done,
	output logic [rpa_pkg::ADDR_W-1:0]        granted_address,
	output logic [rpa_pkg::STATUS_W-1:0]      status,
	output logic                              page_released,
	output logic [rpa_pkg::NCOUNT_W-1:0]      new_count
);

	import rpa_pkg::*;

	logic [ADDR_W-1:0]   region_start_q, region_end_q;
	logic [ADDR_W:0]     base_q;
	logic [DEPTH_W-1:0]  total_q, depth_q, untouched_q;
	logic [FUNC_W-1:0]   func_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [IDX_W-1:0]    idx_q;
	logic                done_q;
	logic [ADDR_W-1:0]   grant_q;
	logic [STATUS_W-1:0] status_q;
	logic                released_q;
	logic [COUNT_BITS-1:0] count_q;

	// Restart arithmetic.
	logic [ADDR_W:0]     rnd;
	logic [ADDR_W:0]     new_base;
	logic [ADDR_W:0]     span;
	logic [PG_W-1:0]     span_pages;
	logic [DEPTH_W-1:0]  new_total;

	// Decode arithmetic.
	logic [ADDR_W:0]     off;
	logic [PG_W-1:0]     pg;
	logic                bad;
	logic [IDX_W-1:0]    idx_calc;
	logic [DEPTH_W-1:0]  depth_m1, untouched_m1;
	logic                have_stack, have_fresh;
	logic [IDX_W-1:0]    pop_idx;
	logic                is_share;

	// Execute arithmetic.
	logic [COUNT_BITS-1:0] cnt, cnt_m1, cnt_p1;
	logic                  not_alloc;

	// Memory ports.
	logic                  stk_we, stk_re;
	logic [IDX_W-1:0]      stk_waddr, stk_raddr, stk_rdata;
	logic                  ref_we, ref_re;
	logic [IDX_W-1:0]      ref_waddr;
	logic [COUNT_BITS-1:0] ref_wdata, ref_rdata;

	// Next values.
	logic [DEPTH_W-1:0]    depth_d, untouched_d;
	logic [ADDR_W-1:0]     grant_d;
	logic [STATUS_W-1:0]   status_d;
	logic                  released_d;
	logic [COUNT_BITS-1:0] count_d;

	always_comb begin
		rnd        = {1'b0, region_start_q} + (ADDR_W+1)'(PAGE_BYTES - 1);
		new_base   = {rnd[ADDR_W:PAGE_SHIFT], PAGE_SHIFT'(0)};
		span       = {1'b0, region_end_q} - new_base;
		span_pages = span[ADDR_W-1:PAGE_SHIFT];
		if ({1'b0, region_end_q} <= new_base) begin
			new_total = '0;
		end else if (span_pages > PG_W'(MAX_PAGES)) begin
			new_total = DEPTH_W'(MAX_PAGES);
		end else begin
			new_total = DEPTH_W'(span_pages);
		end
	end

	always_comb begin
		off          = {1'b0, addr_q} - base_q;
		pg           = off[ADDR_W-1:PAGE_SHIFT];
		bad          = ({1'b0, addr_q} < base_q) || (off[PAGE_SHIFT-1:0] != '0)
			|| (pg >= PG_W'(total_q));
		idx_calc     = pg[IDX_W-1:0];
		depth_m1     = depth_q - DEPTH_W'(1);
		untouched_m1 = untouched_q - DEPTH_W'(1);
		have_stack   = depth_q != '0;
		have_fresh   = untouched_q != '0;
		pop_idx      = have_stack ? stk_rdata : untouched_m1[IDX_W-1:0];
		is_share     = (func_q == FN_FREE) || (func_q == FN_INCREF);
		sts.needs_exec = is_share && !bad;
	end

	always_comb begin
		cnt       = ref_rdata;
		cnt_m1    = cnt - COUNT_BITS'(1);
		cnt_p1    = cnt + COUNT_BITS'(1);
		not_alloc = ({1'b0, idx_q} < untouched_q) || (cnt == '0);
	end

	always_comb begin
		stk_re      = cmd.accept;
		stk_raddr   = depth_m1[IDX_W-1:0];
		stk_we      = 1'b0;
		stk_waddr   = depth_q[IDX_W-1:0];
		ref_re      = cmd.decode && is_share;
		ref_we      = 1'b0;
		ref_waddr   = idx_q;
		ref_wdata   = cnt_m1;
		depth_d     = depth_q;
		untouched_d = untouched_q;
		grant_d     = '0;
		status_d    = ST_OK;
		released_d  = 1'b0;
		count_d     = '0;

		if (cmd.decode) begin
			if (func_q == FN_ALLOC) begin
				if (have_stack || have_fresh) begin
					ref_we    = 1'b1;
					ref_waddr = pop_idx;
					ref_wdata = COUNT_BITS'(1);
					grant_d   = base_q[ADDR_W-1:0] + ADDR_W'({pop_idx, PAGE_SHIFT'(0)});
					count_d   = COUNT_BITS'(1);
					if (have_stack) begin
						depth_d = depth_m1;
					end else begin
						untouched_d = untouched_m1;
					end
				end else begin
					status_d = ST_EMPTY;
				end
			end else if (is_share && bad) begin
				status_d = ST_BADADDR;
			end
		end

		if (cmd.execute) begin
			if (not_alloc) begin
				status_d = ST_NOTALLOC;
			end else if (func_q == FN_FREE) begin
				ref_we    = 1'b1;
				ref_wdata = cnt_m1;
				count_d   = cnt_m1;
				if ((cnt_m1 == '0) && (depth_q < DEPTH_W'(MAX_PAGES))) begin
					stk_we     = 1'b1;
					depth_d    = depth_q + DEPTH_W'(1);
					released_d = 1'b1;
				end
			end else if (cnt == COUNT_MAX) begin
				status_d = ST_SAT;
				count_d  = cnt;
			end else begin
				ref_we    = 1'b1;
				ref_wdata = cnt_p1;
				count_d   = cnt_p1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= RESET_REGION_START;
			region_end_q   <= RESET_REGION_END;
			base_q         <= RESET_BASE;
			total_q        <= RESET_TOTAL;
			depth_q        <= '0;
			untouched_q    <= RESET_TOTAL;
			done_q         <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cfg_we) begin
				if (cfg_index == CFG_REGION_START) begin
					region_start_q <= cfg_wdata;
				end else begin
					region_end_q <= cfg_wdata;
				end
			end
			if (cmd.restart) begin
				base_q      <= new_base;
				total_q     <= new_total;
				depth_q     <= '0;
				untouched_q <= new_total;
			end else begin
				depth_q     <= depth_d;
				untouched_q <= untouched_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
			addr_q <= page_address;
		end
		if (cmd.decode) begin
			idx_q <= idx_calc;
		end
		if (cmd.finish) begin
			grant_q    <= grant_d;
			status_q   <= status_d;
			released_q <= released_d;
			count_q    <= count_d;
		end
	end

	rpa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_PAGES)
	) u_freed_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(idx_q),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	rpa_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_PAGES)
	) u_ref_counts (
		.clk  (clk),
		.we   (ref_we),
		.waddr(ref_waddr),
		.wdata(ref_wdata),
		.re   (ref_re),
		.raddr(idx_calc),
		.rdata(ref_rdata)
	);

	assign done            = done_q;
	assign granted_address = grant_q;
	assign status          = status_q;
	assign page_released   = released_q;
	assign new_count       = NCOUNT_W'(count_q);

endmodule

@@ rtl/rpa_checker.sv @@
// Port-level checker of the page allocator and its bind to the top level.
module rpa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [rpa_pkg::ADDR_W-1:0]    granted_address,
	input logic [rpa_pkg::STATUS_W-1:0]  status,
	input logic                          page_released,
	input logic [rpa_pkg::NCOUNT_W-1:0]  new_count
);

	import rpa_pkg::*;

	// An accepted request keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// No result can appear in the cycle straight after acceptance.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobed too early");

	// Only a successful allocation carries an address.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> granted_address == '0)
		else $error("address given with a failing status");

	// A released page has a count of zero and an ok status.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && page_released |-> new_count == '0 && status == ST_OK)
		else $error("release with non-zero count or bad status");

	// Status codes stay within the defined set.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == ST_OK || status == ST_EMPTY || status == ST_BADADDR
			|| status == ST_NOTALLOC || status == ST_SAT)
		else $error("undefined status code");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.granted_address(granted_address),
	.status         (status),
	.page_released  (page_released),
	.new_count      (new_count)
);
